>>> rtl/hpe_pkg.sv
`default_nettype none
package hpe_pkg;

   localparam int MaxVertices   = 1024;
   localparam int MaxEdges      = 1024;
   localparam int MaxIncidences = 4096;

   localparam int VIdxW   = $clog2(MaxVertices);
   localparam int EIdxW   = $clog2(MaxEdges);
   localparam int IncAddrW = $clog2(MaxIncidences);
   localparam int IdxW    = IncAddrW + 1;
   localparam int CountW  = 11;
   localparam int DegW    = 11;
   localparam int ScoreW  = 32;
   localparam int DampW   = 16;
   localparam int IterW   = 16;
   localparam int DiffW   = 43;
   localparam int DivW    = 33;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;
   localparam int ClearDepth = MaxVertices;

   localparam logic [DegW-1:0] DegMax = '1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_VERTEX_COUNT    = 3'd0,
      CSR_EDGE_COUNT      = 3'd1,
      CSR_DAMPING         = 3'd2,
      CSR_ITERATION_LIMIT = 3'd3,
      CSR_TOLERANCE       = 3'd4
   } csr_index_type;

   typedef struct packed {
      op_type            op;
      logic [VIdxW-1:0]  vertex_index;
      logic [EIdxW-1:0]  edge_index;
   } req_type;

   typedef struct packed {
      logic [ScoreW-1:0] score;
      logic [IterW-1:0]  iterations_done;
      logic              converged;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic [CountW-1:0] vertex_count;
      logic [CountW-1:0] edge_count;
      logic [DampW-1:0]  damping;
      logic [IterW-1:0]  iteration_limit;
      logic [ScoreW-1:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [DegW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_RST_CLR,
      ST_OP_CLR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_READ_RD,
      ST_READ_OUT,
      ST_RUN_DIV0,
      ST_RUN_DIV1,
      ST_INIT,
      ST_EZERO,
      ST_P1_RD,
      ST_P1_CHK,
      ST_P1_DAT,
      ST_P1_DIV,
      ST_AZERO,
      ST_P2_RD,
      ST_P2_CHK,
      ST_P2_DAT,
      ST_P2_DIV,
      ST_P3_RD,
      ST_P3_MUL,
      ST_P3_WR,
      ST_ITER_END,
      ST_DONE
   } state_type;

   function automatic logic [ScoreW-1:0] sat_add(input logic [ScoreW-1:0] a,
                                                 input logic [ScoreW-1:0] b);
      logic [ScoreW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ScoreW] ? '1 : s[ScoreW-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/hpe_divider.sv
`default_nettype none
module hpe_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hpe_pkg::div_req_type div_req,
   output hpe_pkg::div_rsp_type      div_rsp
);

   localparam int CntW = $clog2(hpe_pkg::DivW + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [hpe_pkg::DegW-1:0]    rem_ff, rem_in;
   logic [hpe_pkg::DivW-1:0]    quo_ff, quo_in;
   logic [hpe_pkg::DegW-1:0]    dsr_ff, dsr_in;
   logic [hpe_pkg::DegW:0]      rem_sh;
   logic                        fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, quo_ff[hpe_pkg::DivW-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? hpe_pkg::DegW'(rem_sh - {1'b0, dsr_ff})
                       : rem_sh[hpe_pkg::DegW-1:0];
         quo_in = {quo_ff[hpe_pkg::DivW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(hpe_pkg::DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/hpe_core.sv
`default_nettype none
module hpe_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire hpe_pkg::req_type req,
   input  wire hpe_pkg::cfg_type cfg,
   output logic                  idle,
   output logic                  done,
   output hpe_pkg::rsp_type      rsp
);

   localparam int VW = hpe_pkg::VIdxW;
   localparam int EW = hpe_pkg::EIdxW;
   localparam int AW = hpe_pkg::IncAddrW;
   localparam int IW = hpe_pkg::IdxW;
   localparam int SW = hpe_pkg::ScoreW;
   localparam int DW = hpe_pkg::DegW;
   localparam int CW = hpe_pkg::CountW;

   hpe_pkg::state_type        state_ff, state_in;
   hpe_pkg::req_type          req_ff, req_in;
   logic [IW-1:0]             idx_ff, idx_in, idx_nx;
   logic [IW-1:0]             cnt_ff, cnt_in;
   logic [hpe_pkg::IterW-1:0] it_ff, it_in;
   logic [hpe_pkg::DiffW-1:0] diff_ff, diff_in;
   logic [SW-1:0]             init_ff, init_in;
   logic [SW-1:0]             tele_ff, tele_in;
   logic [VW-1:0]             u_ff, u_in;
   logic [EW-1:0]             ed_ff, ed_in;
   logic [SW-1:0]             acc_ff, acc_in;
   logic [SW+hpe_pkg::DampW-1:0] prod_ff, prod_in;
   logic [SW-1:0]             old_ff, old_in;
   logic [hpe_pkg::IterW-1:0] last_it_ff, last_it_in;
   logic                      last_conv_ff, last_conv_in;
   logic [SW-1:0]             score_ff, score_in;
   hpe_pkg::status_type       status_ff, status_in;

   logic [CW-1:0] n, m;
   logic [SW:0]   pn_sum;
   logic [SW-1:0] pn, absd, quo32;

   hpe_pkg::div_req_type div_req;
   hpe_pkg::div_rsp_type div_rsp;

   logic [VW+EW-1:0] inc_mem [hpe_pkg::MaxIncidences];
   logic [DW-1:0]    deg_mem [hpe_pkg::MaxVertices];
   logic [DW-1:0]    size_mem [hpe_pkg::MaxEdges];
   logic [SW-1:0]    score_mem [hpe_pkg::MaxVertices];
   logic [SW-1:0]    ev_mem [hpe_pkg::MaxEdges];
   logic [SW-1:0]    acc_mem [hpe_pkg::MaxVertices];

   logic [VW+EW-1:0] inc_rd;
   logic [DW-1:0]    deg_rd, size_rd;
   logic [SW-1:0]    score_rd, ev_rd, acc_rd;
   logic [VW-1:0]    inc_v;
   logic [EW-1:0]    inc_e;

   logic             inc_we, deg_we, size_we, score_we, ev_we, acc_we;
   logic [AW-1:0]    inc_wa;
   logic [VW-1:0]    deg_wa, score_wa, acc_wa, deg_ra, score_ra, acc_ra;
   logic [EW-1:0]    size_wa, ev_wa, size_ra, ev_ra;
   logic [DW-1:0]    deg_wd, size_wd;
   logic [SW-1:0]    score_wd, ev_wd, acc_wd;

   hpe_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign n = (cfg.vertex_count > CW'(hpe_pkg::MaxVertices)) ?
              CW'(hpe_pkg::MaxVertices) : cfg.vertex_count;
   assign m = (cfg.edge_count > CW'(hpe_pkg::MaxEdges)) ?
              CW'(hpe_pkg::MaxEdges) : cfg.edge_count;
   assign inc_v  = inc_rd[VW+EW-1:EW];
   assign inc_e  = inc_rd[EW-1:0];
   assign idx_nx = idx_ff + 1'b1;
   assign quo32  = div_rsp.quotient[SW-1:0];
   assign pn_sum = {1'b0, tele_ff} + {1'b0, prod_ff[SW+hpe_pkg::DampW-1:hpe_pkg::DampW]};
   assign pn     = pn_sum[SW] ? '1 : pn_sum[SW-1:0];
   assign absd   = (pn >= old_ff) ? pn - old_ff : old_ff - pn;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      it_in        = it_ff;
      diff_in      = diff_ff;
      init_in      = init_ff;
      tele_in      = tele_ff;
      u_in         = u_ff;
      ed_in        = ed_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      old_in       = old_ff;
      last_it_in   = last_it_ff;
      last_conv_in = last_conv_ff;
      score_in     = score_ff;
      status_in    = status_ff;
      div_req      = '0;
      inc_we = 1'b0; deg_we = 1'b0; size_we = 1'b0;
      score_we = 1'b0; ev_we = 1'b0; acc_we = 1'b0;
      inc_wa   = cnt_ff[AW-1:0];
      deg_wa   = req_ff.vertex_index;
      size_wa  = req_ff.edge_index;
      deg_wd   = '0;
      size_wd  = '0;
      score_wa = idx_ff[VW-1:0];
      score_wd = init_ff;
      ev_wa    = idx_ff[EW-1:0];
      ev_wd    = '0;
      acc_wa   = idx_ff[VW-1:0];
      acc_wd   = '0;
      deg_ra   = inc_v;
      size_ra  = inc_e;
      score_ra = inc_v;
      ev_ra    = inc_e;
      acc_ra   = inc_v;
      idle     = 1'b0;
      done     = 1'b0;

      case (state_ff)
         hpe_pkg::ST_RST_CLR, hpe_pkg::ST_OP_CLR: begin
            deg_we  = 1'b1;
            size_we = 1'b1;
            deg_wa  = idx_ff[VW-1:0];
            size_wa = idx_ff[EW-1:0];
            idx_in  = idx_nx;
            if (idx_nx == IW'(hpe_pkg::ClearDepth)) begin
               idx_in   = '0;
               state_in = (state_ff == hpe_pkg::ST_OP_CLR) ? hpe_pkg::ST_DONE
                                                           : hpe_pkg::ST_IDLE;
            end
         end
         hpe_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               req_in    = req;
               idx_in    = '0;
               score_in  = '0;
               status_in = hpe_pkg::STATUS_OK;
               case (req.op)
                  hpe_pkg::OP_LOAD: begin
                     if (cnt_ff >= IW'(hpe_pkg::MaxIncidences)) begin
                        status_in = hpe_pkg::STATUS_FULL;
                        state_in  = hpe_pkg::ST_DONE;
                     end else begin
                        state_in = hpe_pkg::ST_LOAD_RD;
                     end
                  end
                  hpe_pkg::OP_RUN: begin
                     if (n == '0 || m == '0) begin
                        last_it_in   = '0;
                        last_conv_in = 1'b0;
                        state_in     = hpe_pkg::ST_DONE;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b1, {SW{1'b0}}};
                        div_req.divisor  = n;
                        state_in         = hpe_pkg::ST_RUN_DIV0;
                     end
                  end
                  hpe_pkg::OP_READ: begin
                     if ({1'b0, req.vertex_index} >= n) begin
                        status_in = hpe_pkg::STATUS_RANGE;
                        state_in  = hpe_pkg::ST_DONE;
                     end else begin
                        state_in = hpe_pkg::ST_READ_RD;
                     end
                  end
                  default: begin
                     cnt_in   = '0;
                     state_in = hpe_pkg::ST_OP_CLR;
                  end
               endcase
            end
         end
         hpe_pkg::ST_LOAD_RD: begin
            deg_ra   = req_ff.vertex_index;
            size_ra  = req_ff.edge_index;
            state_in = hpe_pkg::ST_LOAD_WR;
         end
         hpe_pkg::ST_LOAD_WR: begin
            inc_we   = 1'b1;
            deg_we   = 1'b1;
            size_we  = 1'b1;
            deg_wd   = (deg_rd < hpe_pkg::DegMax) ? deg_rd + 1'b1 : deg_rd;
            size_wd  = (size_rd < hpe_pkg::DegMax) ? size_rd + 1'b1 : size_rd;
            cnt_in   = cnt_ff + 1'b1;
            state_in = hpe_pkg::ST_DONE;
         end
         hpe_pkg::ST_READ_RD: begin
            score_ra = req_ff.vertex_index;
            state_in = hpe_pkg::ST_READ_OUT;
         end
         hpe_pkg::ST_READ_OUT: begin
            score_in = score_rd;
            state_in = hpe_pkg::ST_DONE;
         end
         hpe_pkg::ST_RUN_DIV0: begin
            if (div_rsp.done) begin
               init_in = div_rsp.quotient[SW] ? '1 : quo32;
               div_req.start    = 1'b1;
               div_req.dividend = {17'(17'h10000 - {1'b0, cfg.damping}), 16'h0};
               div_req.divisor  = n;
               state_in         = hpe_pkg::ST_RUN_DIV1;
            end
         end
         hpe_pkg::ST_RUN_DIV1: begin
            if (div_rsp.done) begin
               tele_in  = div_rsp.quotient[SW] ? '1 : quo32;
               idx_in   = '0;
               state_in = hpe_pkg::ST_INIT;
            end
         end
         hpe_pkg::ST_INIT: begin
            score_we = 1'b1;
            idx_in   = idx_nx;
            if (idx_nx == IW'(n)) begin
               idx_in  = '0;
               it_in   = '0;
               diff_in = '0;
               if (cfg.iteration_limit == '0) begin
                  last_it_in   = '0;
                  last_conv_in = 1'b0;
                  state_in     = hpe_pkg::ST_DONE;
               end else begin
                  state_in = hpe_pkg::ST_EZERO;
               end
            end
         end
         hpe_pkg::ST_EZERO: begin
            ev_we  = 1'b1;
            idx_in = idx_nx;
            if (idx_nx == IW'(m)) begin
               idx_in   = '0;
               state_in = (cnt_ff == '0) ? hpe_pkg::ST_AZERO : hpe_pkg::ST_P1_RD;
            end
         end
         hpe_pkg::ST_P1_RD, hpe_pkg::ST_P2_RD: begin
            state_in = (state_ff == hpe_pkg::ST_P1_RD) ? hpe_pkg::ST_P1_CHK
                                                       : hpe_pkg::ST_P2_CHK;
         end
         hpe_pkg::ST_P1_CHK, hpe_pkg::ST_P2_CHK: begin
            u_in  = inc_v;
            ed_in = inc_e;
            if ({1'b0, inc_v} >= n || {1'b0, inc_e} >= m) begin
               idx_in = idx_nx;
               if (idx_nx == cnt_ff) begin
                  idx_in   = '0;
                  state_in = (state_ff == hpe_pkg::ST_P1_CHK) ? hpe_pkg::ST_AZERO
                                                              : hpe_pkg::ST_P3_RD;
               end else begin
                  state_in = (state_ff == hpe_pkg::ST_P1_CHK) ? hpe_pkg::ST_P1_RD
                                                              : hpe_pkg::ST_P2_RD;
               end
            end else begin
               state_in = (state_ff == hpe_pkg::ST_P1_CHK) ? hpe_pkg::ST_P1_DAT
                                                           : hpe_pkg::ST_P2_DAT;
            end
         end
         hpe_pkg::ST_P1_DAT, hpe_pkg::ST_P2_DAT: begin
            if ((state_ff == hpe_pkg::ST_P1_DAT && deg_rd == '0) ||
                (state_ff == hpe_pkg::ST_P2_DAT && size_rd == '0)) begin
               idx_in = idx_nx;
               if (idx_nx == cnt_ff) begin
                  idx_in   = '0;
                  state_in = (state_ff == hpe_pkg::ST_P1_DAT) ? hpe_pkg::ST_AZERO
                                                              : hpe_pkg::ST_P3_RD;
               end else begin
                  state_in = (state_ff == hpe_pkg::ST_P1_DAT) ? hpe_pkg::ST_P1_RD
                                                              : hpe_pkg::ST_P2_RD;
               end
            end else begin
               div_req.start = 1'b1;
               if (state_ff == hpe_pkg::ST_P1_DAT) begin
                  acc_in           = ev_rd;
                  div_req.dividend = {1'b0, score_rd};
                  div_req.divisor  = deg_rd;
                  state_in         = hpe_pkg::ST_P1_DIV;
               end else begin
                  acc_in           = acc_rd;
                  div_req.dividend = {1'b0, ev_rd};
                  div_req.divisor  = size_rd;
                  state_in         = hpe_pkg::ST_P2_DIV;
               end
            end
         end
         hpe_pkg::ST_P1_DIV, hpe_pkg::ST_P2_DIV: begin
            ev_wa  = ed_ff;
            ev_wd  = hpe_pkg::sat_add(acc_ff, quo32);
            acc_wa = u_ff;
            acc_wd = hpe_pkg::sat_add(acc_ff, quo32);
            if (div_rsp.done) begin
               ev_we  = (state_ff == hpe_pkg::ST_P1_DIV);
               acc_we = (state_ff == hpe_pkg::ST_P2_DIV);
               idx_in = idx_nx;
               if (idx_nx == cnt_ff) begin
                  idx_in   = '0;
                  state_in = (state_ff == hpe_pkg::ST_P1_DIV) ? hpe_pkg::ST_AZERO
                                                              : hpe_pkg::ST_P3_RD;
               end else begin
                  state_in = (state_ff == hpe_pkg::ST_P1_DIV) ? hpe_pkg::ST_P1_RD
                                                              : hpe_pkg::ST_P2_RD;
               end
            end
         end
         hpe_pkg::ST_AZERO: begin
            acc_we = 1'b1;
            idx_in = idx_nx;
            if (idx_nx == IW'(n)) begin
               idx_in   = '0;
               state_in = (cnt_ff == '0) ? hpe_pkg::ST_P3_RD : hpe_pkg::ST_P2_RD;
            end
         end
         hpe_pkg::ST_P3_RD: begin
            acc_ra   = idx_ff[VW-1:0];
            score_ra = idx_ff[VW-1:0];
            state_in = hpe_pkg::ST_P3_MUL;
         end
         hpe_pkg::ST_P3_MUL: begin
            prod_in  = cfg.damping * acc_rd;
            old_in   = score_rd;
            state_in = hpe_pkg::ST_P3_WR;
         end
         hpe_pkg::ST_P3_WR: begin
            score_we = 1'b1;
            score_wd = pn;
            diff_in  = diff_ff + hpe_pkg::DiffW'(absd);
            idx_in   = idx_nx;
            if (idx_nx == IW'(n)) begin
               idx_in   = '0;
               state_in = hpe_pkg::ST_ITER_END;
            end else begin
               state_in = hpe_pkg::ST_P3_RD;
            end
         end
         hpe_pkg::ST_ITER_END: begin
            diff_in = '0;
            if (diff_ff < hpe_pkg::DiffW'(cfg.tolerance)) begin
               last_it_in   = it_ff + 1'b1;
               last_conv_in = 1'b1;
               state_in     = hpe_pkg::ST_DONE;
            end else if (it_ff + 1'b1 == cfg.iteration_limit) begin
               last_it_in   = cfg.iteration_limit;
               last_conv_in = 1'b0;
               state_in     = hpe_pkg::ST_DONE;
            end else begin
               it_in    = it_ff + 1'b1;
               state_in = hpe_pkg::ST_EZERO;
            end
         end
         hpe_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = hpe_pkg::ST_IDLE;
         end
         default: state_in = hpe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpe_pkg::ST_RST_CLR;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         last_it_ff   <= '0;
         last_conv_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         last_it_ff   <= last_it_in;
         last_conv_ff <= last_conv_in;
      end
      req_ff    <= req_in;
      it_ff     <= it_in;
      diff_ff   <= diff_in;
      init_ff   <= init_in;
      tele_ff   <= tele_in;
      u_ff      <= u_in;
      ed_ff     <= ed_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      old_ff    <= old_in;
      score_ff  <= score_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (inc_we) inc_mem[inc_wa] <= {req_ff.vertex_index, req_ff.edge_index};
      inc_rd <= inc_mem[idx_ff[AW-1:0]];
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      deg_rd <= deg_mem[deg_ra];
      if (size_we) size_mem[size_wa] <= size_wd;
      size_rd <= size_mem[size_ra];
      if (score_we) score_mem[score_wa] <= score_wd;
      score_rd <= score_mem[score_ra];
      if (ev_we) ev_mem[ev_wa] <= ev_wd;
      ev_rd <= ev_mem[ev_ra];
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_rd <= acc_mem[acc_ra];
   end

   assign rsp.score           = score_ff;
   assign rsp.iterations_done = last_it_ff;
   assign rsp.converged       = last_conv_ff;
   assign rsp.status          = status_ff;

endmodule
`default_nettype wire

>>> rtl/hypergraph_pagerank_engine_unit.sv
// Hypergraph PageRank engine.
// req channel (valid/ready): one word per command: load incidence pair, run,
// read score, clear incidence store. rsp channel (valid/ready): one word per
// command with score, last run's iteration count and convergence, status.
// csr port: write-only, write enable / index / data, taken on any edge.
// One command at a time; ready is low while a command is in work.
// A run divides twice, writes start scores, then per iteration clears edge
// values, walks the incidences, clears accumulators, walks them again and
// updates each score, with all divisions in the shared 33-step divider.
// Reset sets the control registers and csr defaults, then sweeps all 1024
// degree and size entries with ready low; csr writes are taken during the sweep.
// A stalled rsp word holds; the next command is accepted as that word
// is taken.
`default_nettype none
module hypergraph_pagerank_engine_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire hpe_pkg::req_type                  req_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output hpe_pkg::rsp_type                       rsp_word,
   input  wire logic                              csr_write_enable,
   input  wire logic [hpe_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [hpe_pkg::CsrDataW-1:0]      csr_write_data
);

   hpe_pkg::cfg_type cfg_ff, cfg_in;
   hpe_pkg::rsp_type rsp_ff, core_rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             core_idle, core_done, accept;

   assign req_ready = core_idle && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   hpe_core u_core (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .req   (req_word),
      .cfg   (cfg_ff),
      .idle  (core_idle),
      .done  (core_done),
      .rsp   (core_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hpe_pkg::CSR_VERTEX_COUNT:
               cfg_in.vertex_count = csr_write_data[hpe_pkg::CountW-1:0];
            hpe_pkg::CSR_EDGE_COUNT:
               cfg_in.edge_count = csr_write_data[hpe_pkg::CountW-1:0];
            hpe_pkg::CSR_DAMPING:
               cfg_in.damping = csr_write_data[hpe_pkg::DampW-1:0];
            hpe_pkg::CSR_ITERATION_LIMIT:
               cfg_in.iteration_limit = csr_write_data[hpe_pkg::IterW-1:0];
            hpe_pkg::CSR_TOLERANCE:
               cfg_in.tolerance = csr_write_data[hpe_pkg::ScoreW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count    <= '0;
         cfg_ff.edge_count      <= '0;
         cfg_ff.damping         <= 16'd55706;
         cfg_ff.iteration_limit <= 16'd100;
         cfg_ff.tolerance       <= 32'd4295;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_done) rsp_ff <= core_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire
